// ===== rtl/iir3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir3_pkg: shared definitions for the three-channel third-order IIR core
// Sample and coefficient formats, register map codes and the rounding and
// saturation helper used on the filter result.
// ----------------------------------------------------------------------------
package iir3_pkg;

	// Fixed-point formats
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 24;
	localparam int COEF_FRAC_BITS = 20;

	// Channel and tap counts
	localparam int CH_N   = 3;
	localparam int HIST_N = 3;
	localparam int FF_N   = HIST_N + 1;
	localparam int FB_N   = HIST_N;
	localparam int REG_N  = FF_N + FB_N;

	// Accumulator: seven products of sample by coefficient, plus guard bits
	localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + 3;
	localparam int RES_W  = ACC_W - COEF_FRAC_BITS;

	// Configuration port
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	// Register map, one 32-bit word per coefficient
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FF_TAP0 = 3'd0,
		REG_FF_TAP1 = 3'd1,
		REG_FF_TAP2 = 3'd2,
		REG_FF_TAP3 = 3'd3,
		REG_FB_TAP1 = 3'd4,
		REG_FB_TAP2 = 3'd5,
		REG_FB_TAP3 = 3'd6
	} reg_idx_t;

	// Unity gain on the current sample
	localparam coef_t FF_TAP0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

	localparam acc_t RND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((2 ** (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-(2 ** (SAMPLE_BITS - 1)));

	// Round half up to an integer sample, then clamp to the sample range
	function automatic sample_t round_sat(input acc_t acc);
		acc_t                     biased;
		logic signed [RES_W-1:0]  whole;
		biased = acc + RND_BIAS;
		whole  = RES_W'(biased >>> COEF_FRAC_BITS);
		if (whole > SAT_MAX) begin
			return SAMPLE_BITS'(SAT_MAX);
		end else if (whole < SAT_MIN) begin
			return SAMPLE_BITS'(SAT_MIN);
		end
		return SAMPLE_BITS'(whole);
	endfunction

endpackage

// ===== rtl/third_order_iir_filter_xyz_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_order_iir_filter_xyz_core: three-channel third-order IIR filter
// Direct-form-I filter on x, y and z with one shared Q4.20 coefficient set,
// four feed-forward and three feedback taps, rounded and saturated output.
//
//   channel   handshake                    beat contents
//   -------   --------------------------   --------------------------------
//   sample    sample_valid / sample_stall  sample_x, sample_y, sample_z,
//                                          enable
//   filt      filt_valid / filt_stall      filtered_x, filtered_y,
//                                          filtered_z
//   apb       psel / penable / pready      paddr, pwrite, pwdata, prdata
//
// One beat is taken per cycle while sample_stall is low; each result passes
// through the input register, then the result register.
// The combinational path from the stage-1 register through seven multiplies,
// the sum, rounding and saturation back into the output history sets fmax.
// Reset clears the histories to zero and loads unity gain on ff_tap0.
// A stalled result holds; the input register still fills behind it, and
// sample_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module third_order_iir_filter_xyz_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Sample channel
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  iir3_pkg::sample_t                  sample_x,
	input  iir3_pkg::sample_t                  sample_y,
	input  iir3_pkg::sample_t                  sample_z,
	input  logic                               enable,
	// Result channel
	output logic                               filt_valid,
	input  logic                               filt_stall,
	output iir3_pkg::sample_t                  filtered_x,
	output iir3_pkg::sample_t                  filtered_y,
	output iir3_pkg::sample_t                  filtered_z,
	// Configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [iir3_pkg::PADDR_W-1:0]       paddr,
	input  logic [iir3_pkg::PDATA_W-1:0]       pwdata,
	output logic [iir3_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);
	import iir3_pkg::*;

	coef_t    ff_q [FF_N];
	coef_t    fb_q [FB_N];
	sample_t  hist_in_q  [CH_N][HIST_N];
	sample_t  hist_out_q [CH_N][HIST_N];

	logic     valid_s1;
	logic     en_s1;
	sample_t  smp_s1 [CH_N];

	logic     valid_s2;
	sample_t  filt_s2 [CH_N];

	logic     adv_s2;
	logic     take_in;
	logic     commit;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	acc_t     acc_c  [CH_N];
	sample_t  filt_c [CH_N];
	coef_t    rd_coef;

	// Handshake: result register frees when empty or taken
	assign adv_s2       = !valid_s2 || !filt_stall;
	assign sample_stall = valid_s1 && !adv_s2;
	assign take_in      = sample_valid && !sample_stall;
	assign commit       = adv_s2 && valid_s1 && en_s1;

	assign filt_valid = valid_s2;
	assign filtered_x = filt_s2[0];
	assign filtered_y = filt_s2[1];
	assign filtered_z = filt_s2[2];

	// Configuration decode
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_FF_TAP0: rd_coef = ff_q[0];
			REG_FF_TAP1: rd_coef = ff_q[1];
			REG_FF_TAP2: rd_coef = ff_q[2];
			REG_FF_TAP3: rd_coef = ff_q[3];
			REG_FB_TAP1: rd_coef = fb_q[0];
			REG_FB_TAP2: rd_coef = fb_q[1];
			REG_FB_TAP3: rd_coef = fb_q[2];
			default:     rd_coef = '0;
		endcase
	end

	assign prdata = PDATA_W'(rd_coef);

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q[0] <= FF_TAP0_RESET;
			for (int i = 1; i < FF_N; i++) ff_q[i] <= '0;
			for (int i = 0; i < FB_N; i++) fb_q[i] <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FF_TAP0: ff_q[0] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FF_TAP1: ff_q[1] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FF_TAP2: ff_q[2] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FF_TAP3: ff_q[3] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FB_TAP1: fb_q[0] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FB_TAP2: fb_q[1] <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_FB_TAP3: fb_q[2] <= coef_t'(pwdata[COEF_BITS-1:0]);
				default: ;
			endcase
		end
	end

	// Stage 1: capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			en_s1     <= enable;
			smp_s1[0] <= sample_x;
			smp_s1[1] <= sample_y;
			smp_s1[2] <= sample_z;
		end
	end

	// Filter each channel: feed-forward minus feedback, then round and clamp; zero when disabled
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			acc_c[ch] = ACC_W'(smp_s1[ch]) * ACC_W'(ff_q[0]);
			for (int k = 0; k < HIST_N; k++) begin
				acc_c[ch] = acc_c[ch]
					+ ACC_W'(hist_in_q[ch][k]) * ACC_W'(ff_q[k+1])
					- ACC_W'(hist_out_q[ch][k]) * ACC_W'(fb_q[k]);
			end
			filt_c[ch] = en_s1 ? round_sat(acc_c[ch]) : '0;
		end
	end

	// Shift histories on an enabled beat leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				for (int k = 0; k < HIST_N; k++) begin
					hist_in_q[ch][k]  <= '0;
					hist_out_q[ch][k] <= '0;
				end
			end
		end else if (commit) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				for (int k = HIST_N - 1; k > 0; k--) begin
					hist_in_q[ch][k]  <= hist_in_q[ch][k-1];
					hist_out_q[ch][k] <= hist_out_q[ch][k-1];
				end
				hist_in_q[ch][0]  <= smp_s1[ch];
				hist_out_q[ch][0] <= filt_c[ch];
			end
		end
	end

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			for (int ch = 0; ch < CH_N; ch++) filt_s2[ch] <= filt_c[ch];
		end
	end

`ifndef ASSERT_OFF
	// Input stalls only when both registers hold beats and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2 && filt_stall))
		else $error("sample_stall raised with room in the pipeline");

	// A disabled beat yields an all-zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && !en_s1) |=>
		(filtered_x == '0 && filtered_y == '0 && filtered_z == '0))
		else $error("disabled beat gave a nonzero result");

	// The newest output history entry matches the result just produced
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (hist_out_q[0][0] == filtered_x && hist_out_q[1][0] == filtered_y
			&& hist_out_q[2][0] == filtered_z))
		else $error("output history out of step with result");

	// Histories hold unless an enabled beat leaves stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> ($stable(hist_out_q[0][0]) && $stable(hist_in_q[0][0])
			&& $stable(hist_out_q[2][2])))
		else $error("history moved without an enabled beat");
`endif

endmodule

// ===== tb/sv/third_order_iir_filter_xyz_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_order_iir_filter_xyz_core_tb: self-checking bench for the xyz IIR core
// Programs the seven Q4.20 taps over APB, streams three-channel sample beats
// with random sender gaps and receiver stalls, and checks every filtered
// beat against a typed result or a cycle-free fixed-point model of the
// filter kept in the bench. A short table of hand-picked beats comes first,
// then random phases, each with a freshly programmed tap set.
// ----------------------------------------------------------------------------
module third_order_iir_filter_xyz_core_tb;

	import iir3_pkg::*;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} xyz_t;

	// Tap sets used by the hand-picked table
	typedef enum {CS_KEEP, CS_HALF, CS_MAX, CS_MIN, CS_MIXED, CS_ZERO} tap_set_t;

	// Flavors of random tap sets
	typedef enum {TAPS_WILD, TAPS_GENTLE, TAPS_EDGE} taps_kind_t;

	typedef struct {
		tap_set_t cs;
		xyz_t     smp;
		logic     en;
		logic     typed;
		xyz_t     res;
	} dir_row_t;

	localparam int      GAP_MAX        = 4;
	localparam int      WATCHDOG_LIMIT = 500;
	localparam int      TAIL_CYCLES    = 8;
	localparam int      PHASE_N        = 9;
	localparam int      PHASE_BEATS    = 150;
	localparam int      REG_STRIDE     = 4;
	localparam int      NO_REG_IDX     = REG_N;
	localparam int      UNITY          = 1 << COEF_FRAC_BITS;
	localparam longint  ROUND_HALF     = longint'(1) << (COEF_FRAC_BITS - 1);
	localparam sample_t SMP_MAX        = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam sample_t SMP_MIN        = sample_t'(-(1 << (SAMPLE_BITS - 1)));
	localparam coef_t   COEF_MAX       = coef_t'((1 << (COEF_BITS - 1)) - 1);
	localparam coef_t   COEF_MIN       = coef_t'(-(1 << (COEF_BITS - 1)));
	localparam coef_t   COEF_HALF      = coef_t'(UNITY / 2);
	localparam xyz_t    XYZ_ZERO       = '0;
	localparam int      DIR_N          = 21;

	// DUT ports
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample_x     = '0;
	sample_t             sample_y     = '0;
	sample_t             sample_z     = '0;
	logic                enable       = 1'b0;
	logic                filt_valid;
	logic                filt_stall   = 1'b0;
	sample_t             filtered_x;
	sample_t             filtered_y;
	sample_t             filtered_z;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [PDATA_W-1:0]  pwdata       = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Filter model state
	coef_t   tap_model [REG_N];
	sample_t in_hist   [CH_N][HIST_N];
	sample_t out_hist  [CH_N][HIST_N];

	xyz_t        filt_expect_q [$];
	logic [31:0] next_words [REG_N];
	int          err_cnt     = 0;
	int          res_cnt     = 0;
	int          stall_left  = 0;
	int          idle_cycles = 0;
	bit          calm        = 1'b0;
	xyz_t        want;

	// Hand-picked beats; typed results hold at a glance, the rest use the model
	dir_row_t dir_rows [DIR_N] = '{
		'{CS_KEEP,  '{16'sd0, 16'sd0, 16'sd0},            1'b1, 1'b1, XYZ_ZERO},
		'{CS_KEEP,  '{SMP_MAX, SMP_MIN, 16'sd1},          1'b1, 1'b1,
			'{SMP_MAX, SMP_MIN, 16'sd1}},
		'{CS_KEEP,  '{SMP_MIN, SMP_MAX, -16'sd1},         1'b1, 1'b1,
			'{SMP_MIN, SMP_MAX, -16'sd1}},
		'{CS_KEEP,  '{16'sd21845, -16'sd21846, 16'sd255}, 1'b1, 1'b1,
			'{16'sd21845, -16'sd21846, 16'sd255}},
		'{CS_KEEP,  '{16'sd1234, -16'sd5, SMP_MAX},       1'b0, 1'b1, XYZ_ZERO},
		'{CS_KEEP,  '{-16'sd1, 16'sd0, SMP_MIN},          1'b1, 1'b1,
			'{-16'sd1, 16'sd0, SMP_MIN}},
		// half gain: ties round up, so -0.5 goes to 0 and -1.5 to -1
		'{CS_HALF,  '{16'sd1, -16'sd1, 16'sd3},           1'b1, 1'b1,
			'{16'sd1, 16'sd0, 16'sd2}},
		'{CS_KEEP,  '{-16'sd3, SMP_MAX, SMP_MIN},         1'b1, 1'b1,
			'{-16'sd1, 16'sd16384, -16'sd16384}},
		'{CS_KEEP,  '{SMP_MAX, SMP_MAX, SMP_MAX},         1'b0, 1'b1, XYZ_ZERO},
		'{CS_MAX,   '{SMP_MAX, SMP_MIN, 16'sd1},          1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{SMP_MAX, SMP_MAX, SMP_MAX},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{16'sd0, 16'sd0, 16'sd0},            1'b0, 1'b1, XYZ_ZERO},
		'{CS_KEEP,  '{SMP_MIN, SMP_MIN, SMP_MIN},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_MIN,   '{SMP_MAX, SMP_MIN, -16'sd1},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{SMP_MIN, SMP_MIN, SMP_MIN},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{16'sd1, -16'sd1, 16'sd100},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_MIXED, '{SMP_MAX, SMP_MIN, 16'sd0},          1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{SMP_MAX, SMP_MAX, SMP_MAX},         1'b1, 1'b0, XYZ_ZERO},
		'{CS_KEEP,  '{-16'sd100, 16'sd100, SMP_MIN},      1'b1, 1'b0, XYZ_ZERO},
		// all taps zero: history no longer matters
		'{CS_ZERO,  '{SMP_MAX, SMP_MIN, 16'sd5},          1'b1, 1'b1, XYZ_ZERO},
		'{CS_KEEP,  '{16'sd1, -16'sd1, 16'sd0},           1'b1, 1'b1, XYZ_ZERO}
	};

	third_order_iir_filter_xyz_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.sample_z     (sample_z),
		.enable       (enable),
		.filt_valid   (filt_valid),
		.filt_stall   (filt_stall),
		.filtered_x   (filtered_x),
		.filtered_y   (filtered_y),
		.filtered_z   (filtered_z),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Run one beat through the filter model; advance histories when enabled
	function automatic void filter_beat(input xyz_t smp, input logic en, output xyz_t res);
		sample_t s [CH_N];
		sample_t y [CH_N];
		longint  acc;
		longint  whole;
		if (!en) begin
			res = XYZ_ZERO;
			return;
		end
		s[0] = smp.x;
		s[1] = smp.y;
		s[2] = smp.z;
		for (int ch = 0; ch < CH_N; ch++) begin
			acc = longint'(s[ch]) * longint'(tap_model[REG_FF_TAP0]);
			for (int k = 0; k < HIST_N; k++) begin
				acc += longint'(in_hist[ch][k]) * longint'(tap_model[REG_FF_TAP1 + k]);
				acc -= longint'(out_hist[ch][k]) * longint'(tap_model[REG_FB_TAP1 + k]);
			end
			whole = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
			if (whole > SMP_MAX) begin
				y[ch] = SMP_MAX;
			end else if (whole < SMP_MIN) begin
				y[ch] = SMP_MIN;
			end else begin
				y[ch] = sample_t'(whole);
			end
			for (int k = HIST_N - 1; k > 0; k--) begin
				in_hist[ch][k]  = in_hist[ch][k-1];
				out_hist[ch][k] = out_hist[ch][k-1];
			end
			in_hist[ch][0]  = s[ch];
			out_hist[ch][0] = y[ch];
		end
		res.x = y[0];
		res.y = y[1];
		res.z = y[2];
	endfunction

	function automatic coef_t preset_tap(input tap_set_t cs, input int idx);
		case (cs)
			CS_HALF:  return (idx == REG_FF_TAP0) ? COEF_HALF : coef_t'(0);
			CS_MAX:   return COEF_MAX;
			CS_MIN:   return COEF_MIN;
			CS_MIXED: return (idx < FF_N) ? COEF_MAX : COEF_MIN;
			default:  return coef_t'(0);
		endcase
	endfunction

	// Junk above the coefficient bits must be ignored by the core
	function automatic logic [31:0] random_tap_word(input taps_kind_t kind, input int idx);
		logic [31:0] word;
		int          v;
		word = $urandom();
		case (kind)
			TAPS_GENTLE: begin
				if (idx < FF_N) begin
					v = int'($urandom_range(0, 2 * UNITY)) - UNITY;
				end else begin
					v = int'($urandom_range(0, UNITY / 2)) - UNITY / 4;
				end
			end
			TAPS_EDGE: begin
				case ($urandom_range(0, 4))
					0:       v = int'(COEF_MAX);
					1:       v = int'(COEF_MIN);
					2:       v = UNITY;
					3:       v = -UNITY;
					default: v = 0;
				endcase
			end
			default: v = int'(word);
		endcase
		word[COEF_BITS-1:0] = v[COEF_BITS-1:0];
		return word;
	endfunction

	function automatic sample_t random_sample();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			return sample_t'($urandom());
		end else if (sel < 8) begin
			return sample_t'(int'($urandom_range(0, 512)) - 256);
		end
		case ($urandom_range(0, 4))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2:       return sample_t'(-1);
			3:       return sample_t'(1);
			default: return sample_t'(0);
		endcase
	endfunction

	// APB write; psel stays high so transfers can run back to back
	// penable is already low on entry: every transfer drops it at its end
	task automatic apb_write(input int idx, input logic [31:0] word);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx < REG_N) begin
			tap_model[idx] = coef_t'(word[COEF_BITS-1:0]);
		end
		penable <= 1'b0;
	endtask

	task automatic apb_read(input int idx);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[COEF_BITS-1:0] !== tap_model[idx]) begin
			report_mismatch($sformatf("tap reg %0d reads %h, want %h",
				idx, prdata[COEF_BITS-1:0], tap_model[idx]));
		end
		penable <= 1'b0;
	endtask

	// Write next_words to every tap, optionally poke an unmapped slot, read all back
	task automatic program_taps(input bit with_stray);
		if (with_stray) begin
			apb_write(NO_REG_IDX, $urandom());
		end
		for (int idx = 0; idx < REG_N; idx++) begin
			apb_write(idx, next_words[idx]);
		end
		for (int idx = 0; idx < REG_N; idx++) begin
			apb_read(idx);
		end
		psel <= 1'b0;
	endtask

	// Drop valid and wait for every filtered beat to come back
	task automatic drain_filter();
		sample_valid <= 1'b0;
		while (filt_expect_q.size() != 0) @(posedge clk);
	endtask

	// Send one sample beat after a random gap (none when calm); hold it until accepted
	task automatic send_sample(input xyz_t smp, input logic en, input logic typed,
			input xyz_t res);
		int   gap;
		xyz_t y;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_x     <= smp.x;
		sample_y     <= smp.y;
		sample_z     <= smp.z;
		enable       <= en;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		filter_beat(smp, en, y);
		filt_expect_q.push_back(typed ? res : y);
	endtask

	task automatic check_field(input string name, input sample_t got, input sample_t exp_val);
		if (got !== exp_val) begin
			report_mismatch($sformatf("result %0d %s = %0d, want %0d",
				res_cnt, name, got, exp_val));
		end
	endtask

	// Check each filtered beat; draw a fresh stall after every accepted one
	always @(posedge clk) begin
		if (arst_n) begin
			if (filt_valid && !filt_stall) begin
				if (filt_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none pending", res_cnt));
				end else begin
					want = filt_expect_q.pop_front();
					check_field("filtered_x", filtered_x, want.x);
					check_field("filtered_y", filtered_y, want.y);
					check_field("filtered_z", filtered_z, want.z);
				end
				res_cnt++;
				stall_left = calm ? 0 : $urandom_range(0, GAP_MAX);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			filt_stall <= (stall_left != 0);
		end
	end

	// Stop a hung run: count cycles with no beat and no register access
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (filt_valid && !filt_stall) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
			$display("third_order_iir_filter_xyz_core_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		xyz_t       smp;
		logic       en;
		taps_kind_t kind;

		for (int idx = 0; idx < REG_N; idx++) begin
			tap_model[idx] = coef_t'(0);
		end
		tap_model[REG_FF_TAP0] = FF_TAP0_RESET;
		for (int ch = 0; ch < CH_N; ch++) begin
			for (int k = 0; k < HIST_N; k++) begin
				in_hist[ch][k]  = '0;
				out_hist[ch][k] = '0;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then a write to an unmapped slot that must change nothing
		for (int idx = 0; idx < REG_N; idx++) begin
			apb_read(idx);
		end
		apb_write(NO_REG_IDX, $urandom());
		psel <= 1'b0;

		// Walk the hand-picked table
		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].cs != CS_KEEP) begin
				drain_filter();
				for (int idx = 0; idx < REG_N; idx++) begin
					next_words[idx] = $urandom();
					next_words[idx][COEF_BITS-1:0] = preset_tap(dir_rows[i].cs, idx);
				end
				program_taps(1'b0);
			end
			send_sample(dir_rows[i].smp, dir_rows[i].en, dir_rows[i].typed, dir_rows[i].res);
		end

		// Random phases, each with its own tap set; every third runs without idling
		for (int ph = 0; ph < PHASE_N; ph++) begin
			drain_filter();
			calm = (ph % 3 == 2);
			kind = taps_kind_t'($urandom_range(0, 2));
			for (int idx = 0; idx < REG_N; idx++) begin
				next_words[idx] = random_tap_word(kind, idx);
			end
			program_taps($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				smp.x = random_sample();
				smp.y = random_sample();
				smp.z = random_sample();
				en    = ($urandom_range(0, 7) != 0);
				send_sample(smp, en, 1'b0, XYZ_ZERO);
			end
		end

		drain_filter();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("third_order_iir_filter_xyz_core_tb: done, clean");
		end else begin
			$display("third_order_iir_filter_xyz_core_tb: done, errors");
		end
		$finish;
	end

endmodule
